>>> rtl/core/oqkr_pkg.sv
// ----------------------------------------------------------------------------
// oqkr_pkg: shared types and codes for the ordered queue
// Request and response payloads, the stored entry layout, operation and
// status codes, and the default capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package oqkr_pkg;

   localparam int OQKR_CAPACITY = 16;

   // Operation codes carried in the func field.
   localparam logic [2:0] FUNC_APPEND = 3'd0;
   localparam logic [2:0] FUNC_POP    = 3'd1;
   localparam logic [2:0] FUNC_DELETE = 3'd2;
   localparam logic [2:0] FUNC_SEARCH = 3'd3;
   localparam logic [2:0] FUNC_CLEAR  = 3'd4;

   // Status codes carried in the response.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] key_id;
      logic [6:0]  entry_age;
      logic [15:0] record_ref;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [15:0] removed_id;
      logic [6:0]  removed_age;
      logic [15:0] removed_ref;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [15:0] key_id;
      logic [6:0]  entry_age;
      logic [15:0] record_ref;
   } entry_type;

endpackage

`default_nettype wire

>>> rtl/core/ordered_queue_keyed_removal.sv
// ----------------------------------------------------------------------------
// ordered_queue_keyed_removal: ordered store with keyed delete
// Holds up to CAPACITY entries in arrival order and runs append, pop head,
// delete by id, search and clear requests one at a time.
// ----------------------------------------------------------------------------
// The entries live in a single-port-read, single-port-write memory, and all
// multi-entry work is done by one id comparator walking that memory under a
// small sequencer, so the block handles one request at a time. With the output
// register free, append, clear and unused codes load their response in the
// cycle after acceptance and take the next request in the cycle after that.
// Search and a failed delete compare one entry per cycle. Pop head and a
// successful delete walk to the match and then move every later entry one
// slot toward the head, one entry per cycle; the memory read port sets this
// pace. A new request is taken as soon as the sequencer is idle, even while
// the previous response still waits in the output register; the sequencer
// only holds its finished result until that register is free. Memory contents
// need no clearing after reset, because only slots below the fill count are
// read.
`default_nettype none

module ordered_queue_keyed_removal
   import oqkr_pkg::*;
#(
   parameter int CAPACITY = OQKR_CAPACITY
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE       = CW'(1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FIND  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   // Control state.
   state_type        state_ff,   state_in;
   logic [CW-1:0]    count_ff,   count_in;
   logic [CW-1:0]    rd_addr_ff, rd_addr_in;
   logic             rd_vld_ff,  rd_vld_in;
   logic [CW-1:0]    rd_idx_ff,  rd_idx_in;
   logic             rsp_vld_ff, rsp_vld_in;

   // Payload state.
   logic [2:0]       op_ff,      op_in;
   logic [15:0]      key_ff,     key_in;
   rsp_type          res_ff,     res_in;
   rsp_type          rsp_ff,     rsp_in;
   entry_type        rd_data_ff;
   entry_type        slots_ff [CAPACITY];

   // Memory port controls.
   logic             issue_en;
   logic [CW-1:0]    issue_addr;
   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   entry_type        mem_wd;
   logic [CW-1:0]    shift_wa;
   logic             hit;
   logic             req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Pop head takes the first entry it reads; the other walks compare ids.
   assign hit = rd_vld_ff && ((op_ff == FUNC_POP) || (rd_data_ff.key_id == key_ff));

   // While shifting, the entry read from slot n is written back to slot n-1.
   assign shift_wa = rd_idx_ff - ONE;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      res_in     = res_ff;
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      issue_en   = 1'b0;
      issue_addr = rd_addr_ff;
      mem_we     = 1'b0;
      mem_wa     = count_ff[AW-1:0];
      mem_wd     = '{key_id:     req_data.key_id,
                     entry_age:  req_data.entry_age,
                     record_ref: req_data.record_ref};

      if (rsp_vld_ff && rsp_ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_data.func;
               key_in   = req_data.key_id;
               res_in   = '0;
               state_in = S_DONE;
               unique case (req_data.func)
                  FUNC_APPEND: begin
                     if (count_ff >= CAP_COUNT) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + ONE;
                     end
                  end
                  FUNC_POP, FUNC_DELETE, FUNC_SEARCH: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        issue_en   = 1'b1;
                        issue_addr = '0;
                        state_in   = S_FIND;
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_FIND: begin
            if (hit) begin
               if (op_ff == FUNC_SEARCH) begin
                  res_in.status = STATUS_OK;
                  res_in.found  = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  // Capture the removed entry, then close the gap behind it.
                  res_in.status      = STATUS_OK;
                  res_in.found       = (op_ff == FUNC_DELETE);
                  res_in.removed_id  = rd_data_ff.key_id;
                  res_in.removed_age = rd_data_ff.entry_age;
                  res_in.removed_ref = rd_data_ff.record_ref;
                  issue_addr         = rd_idx_ff + ONE;
                  issue_en           = (issue_addr < count_ff);
                  state_in           = S_SHIFT;
               end
            end else if (rd_addr_ff >= count_ff) begin
               // The last entry has just been compared without a match.
               res_in.status = STATUS_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               issue_en = 1'b1;
            end
         end

         S_SHIFT: begin
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               mem_wa = shift_wa[AW-1:0];
               mem_wd = rd_data_ff;
            end
            if (rd_addr_ff < count_ff) begin
               issue_en = 1'b1;
            end else begin
               count_in = count_ff - ONE;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_vld_ff || rsp_ready) begin
               rsp_in           = res_ff;
               rsp_in.occupancy = 5'(count_ff);
               rsp_vld_in       = 1'b1;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_vld_in  = issue_en;
      rd_idx_in  = issue_addr;
      rd_addr_in = issue_en ? (issue_addr + ONE) : issue_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rd_addr_ff <= '0;
         rd_vld_ff  <= 1'b0;
         rd_idx_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_addr_ff <= rd_addr_in;
         rd_vld_ff  <= rd_vld_in;
         rd_idx_ff  <= rd_idx_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots_ff[mem_wa] <= mem_wd;
      end
      if (issue_en) begin
         rd_data_ff <= slots_ff[issue_addr[AW-1:0]];
      end
   end

   // The fill count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CAP_COUNT)
      else $error("fill count above capacity");

   // An accepted request always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // An append into a store with room grows the fill count by one.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.func == FUNC_APPEND) && (count_ff < CAP_COUNT))
      |=> (count_ff == $past(count_ff) + ONE))
      else $error("append did not grow the fill count");

   // The shift never writes back from the head slot.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SHIFT) && rd_vld_ff) |-> (rd_idx_ff != '0))
      else $error("shift read returned the head slot");

endmodule

`default_nettype wire
